// File: src/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/sha1s_pkg.sv
// types, constants and helper functions for the sha-1 stream hasher
// no dependencies
package sha1s_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef logic [4:0][31:0] words5_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
    } sched_ctl_t;

    typedef struct packed {
        logic       start;
        logic       step;
        logic       fold;
        logic       reinit;
        logic [6:0] round_idx;
    } round_ctl_t;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd55;

    localparam words5_t INIT_VECTOR = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    function automatic logic [31:0] round_const(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)
        begin
            k = 32'h5A827999;
        end
        else if (rnd < 7'd40)
        begin
            k = 32'h6ED9EBA1;
        end
        else if (rnd < 7'd60)
        begin
            k = 32'h8F1BBCDC;
        end
        else
        begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// File: src/sha1_stream_hasher.sv
// sha-1 of a byte stream: one word per byte, five digest words per message
// a byte that does not complete a block is taken while idle; the 64th byte of a block starts
// the 80 rounds on the shared round unit and then a fold, and input stalls until they are through
// a last word adds the padding and length bytes and one or two compressions,
// then five digest words leave from an output register while the next message is taken
// async active-low reset: chaining words to the initial vector, counters cleared, output empty
`include "assert_macros.svh"

module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [6:0]  rnd_reg;
    logic [6:0]  rnd_next;
    logic        pend_last_reg;
    logic        pend_last_next;
    logic        pad_first_reg;
    logic        pad_first_next;
    logic        fin_reg;
    logic        fin_next;
    logic        load_out;
    logic        out_take;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    words5_t     dig_reg;
    words5_t     dig_next;
    words5_t     chain;
    logic [31:0] w;
    sched_ctl_t  sched_ctl;
    round_ctl_t  round_ctl;

    sha1s_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (w)
    );

    sha1s_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (round_ctl),
        .w     (w),
        .chain (chain)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid && cnt_reg == BLOCK_LAST)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (cnt_reg == BLOCK_LAST)
                begin
                    state_next = ST_ROUND;
                end
                else if (cnt_reg == LEN_START)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (cnt_reg == BLOCK_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (fin_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (pend_last_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sched_ctl      = '0;
        round_ctl      = '0;
        round_ctl.round_idx = rnd_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        pend_last_next = pend_last_reg;
        pad_first_next = pad_first_reg;
        fin_next       = fin_reg;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pend_last_next = last;
                    pad_first_next = 1'b1;
                    if (byte_valid)
                    begin
                        sched_ctl.push      = 1'b1;
                        sched_ctl.push_byte = data_byte;
                        cnt_next            = cnt_reg + 6'd1;
                        len_next            = len_reg + 64'd8;
                        if (cnt_reg == BLOCK_LAST)
                        begin
                            round_ctl.start = 1'b1;
                            rnd_next        = '0;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                sched_ctl.push      = 1'b1;
                sched_ctl.push_byte = pad_first_reg ? PAD_BYTE : ZERO_BYTE;
                pad_first_next      = 1'b0;
                cnt_next            = cnt_reg + 6'd1;
                if (cnt_reg == BLOCK_LAST)
                begin
                    round_ctl.start = 1'b1;
                    rnd_next        = '0;
                end
            end
            ST_LEN:
            begin
                sched_ctl.push      = 1'b1;
                sched_ctl.push_byte = len_reg[63:56];
                len_next            = {len_reg[55:0], 8'h00};
                cnt_next            = cnt_reg + 6'd1;
                fin_next            = 1'b1;
                if (cnt_reg == BLOCK_LAST)
                begin
                    round_ctl.start = 1'b1;
                    rnd_next        = '0;
                end
            end
            ST_ROUND:
            begin
                sched_ctl.step = 1'b1;
                round_ctl.step = 1'b1;
                rnd_next       = rnd_reg + 7'd1;
            end
            ST_FOLD:
            begin
                round_ctl.fold = 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    round_ctl.reinit = 1'b1;
                    load_out         = 1'b1;
                    pend_last_next   = 1'b0;
                    fin_next         = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        dig_next       = dig_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            idx_next       = '0;
            dig_next       = chain;
        end
        else if (out_take)
        begin
            if (idx_reg == 3'd4)
            begin
                out_valid_next = 1'b0;
            end
            idx_next = idx_reg + 3'd1;
            for (int i = 0; i < 4; i++)
            begin
                dig_next[i] = dig_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            pend_last_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            rnd_reg       <= rnd_next;
            pend_last_reg <= pend_last_next;
            pad_first_reg <= pad_first_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd4);

    `ASSERT_CLK(a_out_from_done, $rose(out_valid) |-> $past(state_reg == ST_DONE), "digest without finished message")
    `ASSERT_CLK(a_out_drains, (out_take && last_word) |=> !out_valid, "digest word after the fifth")
    `ASSERT_NEVER(a_round_full, (state_reg == ST_ROUND && cnt_reg != 6'd0), "rounds on a partial block")
    `ASSERT_NEVER(a_done_clean, (state_reg == ST_DONE && (cnt_reg != 6'd0 || len_reg != 64'd0)), "message state not cleared at digest")

endmodule

// File: src/sha1s_sched.sv
// message block window and sha-1 message schedule as a 16-word shift line
// depends on sha1s_pkg
module sha1s_sched
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  sched_ctl_t  ctl,
    output logic [31:0] w
);

    logic [15:0][31:0] win_reg;
    logic [15:0][31:0] win_next;
    logic [31:0]       mix;

    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w   = win_reg[0];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctl.push_byte};
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = {mix[30:0], mix[31]};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// File: src/sha1s_round.sv
// sha-1 round unit with working variables and chaining words
// depends on sha1s_pkg
module sha1s_round
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  round_ctl_t  ctl,
    input  logic [31:0] w,
    output words5_t     chain
);

    words5_t     chain_reg;
    words5_t     chain_next;
    words5_t     work_reg;
    words5_t     work_next;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] t;

    assign b     = work_reg[1];
    assign c     = work_reg[2];
    assign d     = work_reg[3];
    assign chain = chain_reg;

    always_comb
    begin
        if (ctl.round_idx < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (ctl.round_idx inside {[7'd20:7'd39], [7'd60:7'd127]})
        begin
            f = b ^ c ^ d;
        end
        else
        begin
            f = (b & c) | (b & d) | (c & d);
        end
    end

    assign t = {work_reg[0][26:0], work_reg[0][31:27]} + f + work_reg[4]
             + round_const(ctl.round_idx) + w;

    always_comb
    begin
        work_next = work_reg;
        if (ctl.start)
        begin
            work_next = chain_reg;
        end
        else if (ctl.step)
        begin
            work_next[4] = d;
            work_next[3] = c;
            work_next[2] = {b[1:0], b[31:2]};
            work_next[1] = work_reg[0];
            work_next[0] = t;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctl.reinit)
        begin
            chain_next = INIT_VECTOR;
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_VECTOR;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for sha1_stream_hasher: byte words in, five digest words out per message
// predicts each digest with its own sha-1 model; needs only the rtl and its package

module testbench;

    localparam int WORD_TARGET    = 410;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_entry_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = 8'h00;
    logic        byte_valid = 1'b0;
    logic        last       = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_entry_t digest_q[$];
    logic [7:0]    msg_block [64];
    logic [31:0]   chain [5];
    int unsigned   held_bytes;
    logic [63:0]   done_bits;

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  idle_cycles    = 0;
    int  stall_left     = 0;
    bit  steady_flow    = 1'b0;

    sha1_stream_hasher u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic clear_message();
        chain[0]   = 32'h67452301;
        chain[1]   = 32'hEFCDAB89;
        chain[2]   = 32'h98BADCFE;
        chain[3]   = 32'h10325476;
        chain[4]   = 32'hC3D2E1F0;
        held_bytes = 0;
        done_bits  = 64'd0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4 * i], msg_block[4 * i + 1],
                    msg_block[4 * i + 2], msg_block[4 * i + 3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
                w[r % 16] = {x[30:0], x[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic predict_digest(input logic [7:0] b, input logic bv, input logic lst);
        int unsigned   n;
        logic [63:0]   total;
        digest_entry_t entry;
        if (bv)
        begin
            msg_block[held_bytes] = b;
            held_bytes++;
            if (held_bytes == 64)
            begin
                sha1_compress();
                done_bits += 64'd512;
                held_bytes = 0;
            end
        end
        if (lst)
        begin
            n = held_bytes;
            total = done_bits + 64'(n * 8);
            msg_block[n] = 8'h80;
            for (int i = n + 1; i < 64; i++)
            begin
                msg_block[i] = 8'h00;
            end
            if (n >= 56)
            begin
                sha1_compress();
                for (int i = 0; i < 56; i++)
                begin
                    msg_block[i] = 8'h00;
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[63 - i] = total[8 * i +: 8];
            end
            sha1_compress();
            for (int i = 0; i < 5; i++)
            begin
                entry.word    = chain[i];
                entry.index   = 3'(i);
                entry.is_last = (i == 4);
                digest_q.push_back(entry);
            end
            clear_message();
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic bv, input logic lst);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        byte_valid <= bv;
        last       <= lst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_digest(b, bv, lst);
        words_sent++;
    endtask

    // random bytes, stray empty words now and then, last either on the final byte or on its own
    task automatic send_message(input int len, input bit last_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
        end
        if (!last_on_byte || len == 0)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_empty_message();
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_words();
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_short_messages();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        send_message(2, 1'b1);
        send_message(2, 1'b1);
        send_message(0, 1'b0);
        steady_flow = 1'b0;
    endtask

    task automatic test_block_edges();
        send_message(55, 1'($urandom_range(0, 1)));
        send_message(56, 1'($urandom_range(0, 1)));
        send_message(63, 1'b1);
        send_message(64, 1'b1);
        send_message(64, 1'b0);
    endtask

    task automatic test_random_messages();
        int sel;
        int len;
        while (words_sent < WORD_TARGET)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                len = $urandom_range(0, 12);
            end
            else if (sel < 9)
            begin
                len = $urandom_range(50, 70);
            end
            else
            begin
                len = $urandom_range(110, 140);
            end
            if (len > WORD_TARGET - words_sent)
            begin
                len = WORD_TARGET - words_sent;
            end
            send_message(len, 1'($urandom_range(0, 1)));
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        digest_entry_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected digest word %h index %0d last %b",
                                 digest_word, word_index, last_word);
                    end
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.word || word_index !== want.index
                        || last_word !== want.is_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     want.word, want.index, want.is_last,
                                     digest_word, word_index, last_word);
                        end
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("sha1_stream_hasher regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        clear_message();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_message();
        test_ignored_words();
        test_short_messages();
        test_back_to_back();
        test_block_edges();
        test_random_messages();
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("sha1_stream_hasher regression: pass");
        end
        else
        begin
            $display("sha1_stream_hasher regression: fail");
        end
        $finish;
    end

endmodule

// File: sha1_stream_hasher.f
+incdir+src
src/sha1s_pkg.sv
src/sha1s_sched.sv
src/sha1s_round.sv
src/sha1_stream_hasher.sv
tb/sv/testbench.sv
